### hdl/fdtsp_pkg.sv
// shared types and constants of the device-tree structure block parser
`default_nettype none

package fdtsp_pkg;

    // parameter defaults
    localparam int MaxDepthDefault      = 64;
    localparam int MaxBlockBytesDefault = 16777216;

    // register file
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 32;
    localparam int SizeRegW  = 25;

    localparam logic [CfgIndexW-1:0] CfgStructSize  = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgStringsSize = 2'd1;

    localparam logic [SizeRegW-1:0] StructSizeReset  = 25'd4;
    localparam logic [SizeRegW-1:0] StringsSizeReset = 25'd0;

    // structure block tokens
    localparam logic [31:0] TokBeginNode = 32'h0000_0001;
    localparam logic [31:0] TokEndNode   = 32'h0000_0002;
    localparam logic [31:0] TokProp      = 32'h0000_0003;
    localparam logic [31:0] TokNop       = 32'h0000_0004;
    localparam logic [31:0] TokEnd       = 32'h0000_0009;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_BEGIN    = 3'd1,
        EV_END      = 3'd2,
        EV_PROP     = 3'd3,
        EV_VALUE    = 3'd4,
        EV_FINISHED = 3'd5,
        EV_ERROR    = 3'd6
    } t_event;

    typedef enum logic [4:0] {
        PH_TOKEN   = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_NAMEOFF = 5'b01000,
        PH_VALUE   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [31:0] word;
        logic        first;
    } t_fdt_in;

    typedef struct packed {
        t_event      event_kind;
        logic [5:0]  depth;
        logic [23:0] prop_length;
        logic [23:0] str_offset;
        logic [31:0] value_word;
        logic        value_last;
    } t_fdt_out;

    function automatic logic has_zero_byte(input logic [31:0] w);
        return (w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
               (w[15:8] == 8'd0) || (w[7:0] == 8'd0);
    endfunction

endpackage

`default_nettype wire

### hdl/fdt_structure_block_parser_core.sv
// top level of the device-tree structure block parser
`default_nettype none

// Streaming parser for the structure block of a flattened device tree. Each
// input item is one big-endian 32-bit word of the block; each item gives
// exactly one result item (none, begin node, end node, property header,
// value word, finished or error). An item marked first restarts the parse.
// Errors are sticky until the next first item. The block takes one item per
// cycle while the input is not stalled: an item is held in an input register,
// decoded against the parser state in a single pass and written into a
// two-entry output queue, so an item can still be taken while one finished
// result waits at the output. Input stall rises only when the queue is full
// and a word waits in the input register. Configuration registers
// (structure size, strings size) are written through a separate port that is
// always ready and must be written only while the parser is idle.
module fdt_structure_block_parser_core #(
    parameter int MAX_DEPTH       = fdtsp_pkg::MaxDepthDefault,
    parameter int MAX_BLOCK_BYTES = fdtsp_pkg::MaxBlockBytesDefault
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // word channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire fdtsp_pkg::t_fdt_in          i_in,
    // event channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output fdtsp_pkg::t_fdt_out              o_out,
    // configuration writes
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [fdtsp_pkg::CfgIndexW-1:0]   i_cfg_index,
    input  wire [fdtsp_pkg::CfgDataW-1:0]    i_cfg_data
);

    import fdtsp_pkg::*;

    // depth counter holds 0..MAX_DEPTH, word counters hold 0..block words
    localparam int DepthW = $clog2(MAX_DEPTH + 1);
    localparam int WordsW = $clog2(MAX_BLOCK_BYTES / 4 + 1);

    localparam logic [SizeRegW-1:0] MaxBytes = SizeRegW'(MAX_BLOCK_BYTES);
    localparam logic [DepthW-1:0]   DepthMax = DepthW'(MAX_DEPTH);

    // configuration
    logic [SizeRegW-1:0] r_struct_size;
    logic [SizeRegW-1:0] r_strings_size;

    // input register
    logic                r_in_valid;
    t_fdt_in             r_in;

    // parser state
    t_phase              r_phase;
    logic [DepthW-1:0]   r_depth;
    logic [WordsW-1:0]   r_words_seen;
    logic [WordsW-1:0]   r_words_left;
    logic [23:0]         r_held_length;
    logic                r_done;
    logic                r_error;

    t_phase              n_phase;
    logic [DepthW-1:0]   n_depth;
    logic [WordsW-1:0]   n_words_seen;
    logic [WordsW-1:0]   n_words_left;
    logic [23:0]         n_held_length;
    logic                n_done;
    logic                n_error;

    // output queue, entry 0 is the head
    t_fdt_out            r_q0;
    t_fdt_out            r_q1;
    logic [1:0]          r_cnt;

    // decode signals
    t_phase              eff_phase;
    logic [DepthW-1:0]   eff_depth;
    logic [WordsW-1:0]   eff_words_seen;
    logic [WordsW-1:0]   eff_words_left;
    logic [23:0]         eff_held_length;
    logic                eff_done;
    logic                eff_error;

    logic [SizeRegW-1:0] struct_clamped;
    logic [SizeRegW-1:0] strings_clamped;
    logic [WordsW-1:0]   size_words;
    logic [WordsW-1:0]   seen_inc;
    logic [WordsW-1:0]   left;
    logic [WordsW-1:0]   words_left_dec;
    logic [30:0]         padded_words;
    logic [31:0]         w;
    logic                fail;
    t_event              kind;
    logic [DepthW-1:0]   d;
    logic [23:0]         plen;
    logic [23:0]         noff;
    logic [31:0]         vw;
    logic                vl;
    t_fdt_out            res;

    logic                enq;
    logic                deq;
    logic                in_take;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    // the word in the input register moves on whenever a queue slot is free
    assign enq         = r_in_valid && (r_cnt != 2'd2);
    assign deq         = (r_cnt != 2'd0) && !i_out_stall;
    assign o_in_stall  = r_in_valid && (r_cnt == 2'd2);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_q0;

    // ---------------------------------------------------------------
    // configuration registers, unknown indexes are dropped
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_struct_size  <= StructSizeReset;
            r_strings_size <= StringsSizeReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CfgStructSize:  r_struct_size  <= i_cfg_data[SizeRegW-1:0];
                CfgStringsSize: r_strings_size <= i_cfg_data[SizeRegW-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to the largest block supported
    assign struct_clamped  = (r_struct_size > MaxBytes) ? MaxBytes : r_struct_size;
    assign strings_clamped = (r_strings_size > MaxBytes) ? MaxBytes : r_strings_size;
    assign size_words      = WordsW'(struct_clamped >> 2);

    // ---------------------------------------------------------------
    // single-pass decode of the registered word
    // ---------------------------------------------------------------
    assign w = r_in.word;

    always_comb begin
        // a first word restarts from the reset state
        if (r_in.first) begin
            eff_phase       = PH_TOKEN;
            eff_depth       = '0;
            eff_words_seen  = '0;
            eff_words_left  = '0;
            eff_held_length = '0;
            eff_done        = 1'b0;
            eff_error       = 1'b0;
        end else begin
            eff_phase       = r_phase;
            eff_depth       = r_depth;
            eff_words_seen  = r_words_seen;
            eff_words_left  = r_words_left;
            eff_held_length = r_held_length;
            eff_done        = r_done;
            eff_error       = r_error;
        end

        n_phase       = eff_phase;
        n_depth       = eff_depth;
        n_words_seen  = eff_words_seen;
        n_words_left  = eff_words_left;
        n_held_length = eff_held_length;
        n_done        = eff_done;
        n_error       = eff_error;

        seen_inc       = eff_words_seen + 1'b1;
        left           = size_words - seen_inc;
        words_left_dec = (eff_words_left != '0) ? eff_words_left - 1'b1 : '0;
        // value length rounded up to whole words
        padded_words   = 31'(({1'b0, w} + 33'd3) >> 2);

        fail = 1'b0;
        kind = EV_NONE;
        d    = '0;
        plen = '0;
        noff = '0;
        vw   = '0;
        vl   = 1'b0;

        if (eff_error) begin
            kind = EV_ERROR;
        end else if (eff_done) begin
            kind = EV_NONE;
        end else if (eff_words_seen >= size_words) begin
            // word beyond the end of the block
            fail = 1'b1;
        end else begin
            n_words_seen = seen_inc;
            unique case (eff_phase)
                PH_TOKEN: begin
                    if (w == TokNop) begin
                        kind = EV_NONE;
                    end else if (w == TokEnd) begin
                        if (eff_depth == '0) begin
                            n_done = 1'b1;
                            kind   = EV_FINISHED;
                        end else begin
                            fail = 1'b1;
                        end
                    end else if (w == TokBeginNode) begin
                        n_phase = PH_NAME;
                    end else if (w == TokEndNode) begin
                        if (eff_depth == '0) begin
                            fail = 1'b1;
                        end else begin
                            n_depth = eff_depth - 1'b1;
                            kind    = EV_END;
                            d       = eff_depth - 1'b1;
                        end
                    end else if (w == TokProp) begin
                        // length and name offset words must still fit
                        if (left < WordsW'(2)) begin
                            fail = 1'b1;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_NAME: begin
                    // name ends in the word holding a nul byte
                    if (has_zero_byte(w)) begin
                        if (eff_depth >= DepthMax) begin
                            fail = 1'b1;
                        end else begin
                            kind    = EV_BEGIN;
                            d       = eff_depth;
                            n_depth = eff_depth + 1'b1;
                            n_phase = PH_TOKEN;
                        end
                    end
                end
                PH_LEN: begin
                    // padded value must fit after the name offset word
                    if (left == '0 ||
                        padded_words > 31'(left - 1'b1)) begin
                        fail = 1'b1;
                    end else begin
                        n_held_length = w[23:0];
                        n_words_left  = WordsW'(padded_words);
                        n_phase       = PH_NAMEOFF;
                    end
                end
                PH_NAMEOFF: begin
                    if (w >= 32'(strings_clamped) || eff_depth == '0) begin
                        fail = 1'b1;
                    end else begin
                        kind    = EV_PROP;
                        d       = eff_depth - 1'b1;
                        plen    = eff_held_length;
                        noff    = w[23:0];
                        n_phase = (eff_words_left != '0) ? PH_VALUE : PH_TOKEN;
                    end
                end
                PH_VALUE: begin
                    kind         = EV_VALUE;
                    d            = (eff_depth != '0) ? eff_depth - 1'b1 : '0;
                    plen         = eff_held_length;
                    vw           = w;
                    vl           = (eff_words_left == WordsW'(1));
                    n_words_left = words_left_dec;
                    if (words_left_dec == '0) begin
                        n_phase = PH_TOKEN;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        // errors latch and report the current depth only
        if (fail) begin
            n_error = 1'b1;
            kind    = EV_ERROR;
        end
        if (kind == EV_ERROR) begin
            d    = eff_depth;
            plen = '0;
            noff = '0;
            vw   = '0;
            vl   = 1'b0;
        end

        res.event_kind  = kind;
        res.depth       = 6'(d);
        res.prop_length = plen;
        res.str_offset  = noff;
        res.value_word  = vw;
        res.value_last  = vl;
    end

    // ---------------------------------------------------------------
    // input register and parser state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (enq) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TOKEN;
            r_depth       <= '0;
            r_words_seen  <= '0;
            r_words_left  <= '0;
            r_held_length <= '0;
            r_done        <= 1'b0;
            r_error       <= 1'b0;
        end else if (enq) begin
            r_phase       <= n_phase;
            r_depth       <= n_depth;
            r_words_seen  <= n_words_seen;
            r_words_left  <= n_words_left;
            r_held_length <= n_held_length;
            r_done        <= n_done;
            r_error       <= n_error;
        end
    end

    // ---------------------------------------------------------------
    // two-entry output queue
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({enq, deq})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({enq, deq})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_q0 <= res;
                end else begin
                    r_q1 <= res;
                end
            end
            2'b01: begin
                r_q0 <= r_q1;
            end
            2'b11: begin
                // one entry held and leaving, new item takes the head
                r_q0 <= res;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
